/* sv/tlb_page_table_translate_defines.svh */
// Assertion macros used by the address translation lookup engine.
`ifndef TLB_PAGE_TABLE_TRANSLATE_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset-qualified.
`define TPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/tpt_pkg.sv */
// Shared types and constants for the TLB / page table translation block.
`default_nettype none

package tpt_pkg;

	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 3;
	localparam int PA_W        = 28;
	localparam int FRAME_W     = 16;
	localparam int PIDX_W      = 16;
	localparam int VA_W        = 32;
	// widest page number and offset over the supported parameter range
	localparam int PAGE_MAX_W  = 12;
	localparam int OFF_MAX_W   = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [IN_TUSER_W-1:0] OP_TRANSLATE = 2'd0;
	localparam logic [IN_TUSER_W-1:0] OP_MAP       = 2'd1;
	localparam logic [IN_TUSER_W-1:0] OP_PROTECT   = 2'd2;

	typedef enum logic [OUT_TUSER_W-1:0] {
		ST_HIT     = 3'd0,
		ST_FILLED  = 3'd1,
		ST_RANGE   = 3'd2,
		ST_PFAULT  = 3'd3,
		ST_PROT    = 3'd4,
		ST_DONE    = 3'd5,
		ST_BADPAGE = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		K_TRANSLATE = 2'd0,
		K_MAP       = 2'd1,
		K_PROTECT   = 2'd2,
		K_BAD       = 2'd3
	} kind_t;

	typedef logic [PAGE_MAX_W-1:0] page_fld_t;
	typedef logic [OFF_MAX_W-1:0]  off_fld_t;

	typedef struct packed {
		kind_t                kind;
		logic                 in_range;
		page_fld_t            page;
		page_fld_t            quot;     // page / TLB_ENTRIES
		off_fld_t             offset;
		logic                 wr;
		logic [FRAME_W-1:0]   frame;
		logic                 ro;
	} entry_t;

endpackage

`default_nettype wire

/* sv/tpt_front.sv */
// Front end: unpacks an input beat, classifies it and precomputes page and slot quotient.
`default_nettype none

module tpt_front #(
	parameter int OFFSET_BITS   = 12,
	parameter int TLB_ENTRIES   = 16,
	parameter int VIRTUAL_PAGES = 256
) (
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [tpt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [tpt_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	input  wire logic                           clear_busy,
	input  wire logic                           q_full,
	output logic                                push,
	output tpt_pkg::entry_t                     push_entry
);

	localparam int PAGE_W    = $clog2(VIRTUAL_PAGES);
	localparam int SLOT_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	// reciprocal, exact for every PAGE_W-bit numerator
	localparam int MOD_SHIFT = PAGE_W + SLOT_W + 1;
	localparam int MUL_W     = MOD_SHIFT + 1;
	localparam int PROD_W    = PAGE_W + MUL_W;
	localparam logic [MUL_W-1:0] MOD_MUL =
		MUL_W'(((1 << MOD_SHIFT) + TLB_ENTRIES - 1) / TLB_ENTRIES);

	logic [tpt_pkg::VA_W-1:0]    va;
	logic                        wr;
	logic [tpt_pkg::PIDX_W-1:0]  pidx;
	logic [tpt_pkg::FRAME_W-1:0] frame;
	logic                        ro;
	logic [tpt_pkg::VA_W-1:0]    va_page;
	logic                        va_in_range;
	logic                        pidx_in_range;
	tpt_pkg::kind_t              kind;
	tpt_pkg::page_fld_t          page_sel;
	logic                        range_sel;
	logic [PAGE_W-1:0]           page_pw;
	logic [PROD_W-1:0]           prod;

	assign va    = s_axis_tdata[31:0];
	assign wr    = s_axis_tdata[32];
	assign pidx  = s_axis_tdata[48:33];
	assign frame = s_axis_tdata[64:49];
	assign ro    = s_axis_tdata[65];

	assign va_page       = va >> OFFSET_BITS;
	assign va_in_range   = va_page < tpt_pkg::VA_W'(VIRTUAL_PAGES);
	assign pidx_in_range = tpt_pkg::VA_W'(pidx) < tpt_pkg::VA_W'(VIRTUAL_PAGES);

	always_comb begin
		unique case (s_axis_tuser)
			tpt_pkg::OP_TRANSLATE: kind = tpt_pkg::K_TRANSLATE;
			tpt_pkg::OP_MAP:       kind = tpt_pkg::K_MAP;
			tpt_pkg::OP_PROTECT:   kind = tpt_pkg::K_PROTECT;
			default:               kind = tpt_pkg::K_BAD;
		endcase
	end

	always_comb begin
		if (kind == tpt_pkg::K_TRANSLATE) begin
			page_sel  = va_page[tpt_pkg::PAGE_MAX_W-1:0];
			range_sel = va_in_range;
		end else begin
			page_sel  = pidx[tpt_pkg::PAGE_MAX_W-1:0];
			range_sel = pidx_in_range;
		end
	end

	assign page_pw = page_sel[PAGE_W-1:0];
	assign prod    = PROD_W'(page_pw) * PROD_W'(MOD_MUL);

	assign s_axis_tready = !q_full && !clear_busy;
	assign push          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		push_entry.kind     = kind;
		push_entry.in_range = range_sel;
		push_entry.page     = page_sel;
		push_entry.quot     = tpt_pkg::page_fld_t'(prod[MOD_SHIFT +: PAGE_W]);
		push_entry.offset   = tpt_pkg::off_fld_t'(va[OFFSET_BITS-1:0]);
		push_entry.wr       = wr;
		push_entry.frame    = frame;
		push_entry.ro       = ro;
	end

endmodule

`default_nettype wire

/* sv/tpt_queue.sv */
// Two-entry queue decoupling the front end from the lookup engine.
`default_nettype none

module tpt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  tpt_pkg::entry_t      push_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 pop_valid,
	output tpt_pkg::entry_t      pop_entry
);

	tpt_pkg::entry_t                entries_q [tpt_pkg::QUEUE_DEPTH];
	logic [tpt_pkg::QPTR_W-1:0]     wptr_q;
	logic [tpt_pkg::QPTR_W-1:0]     rptr_q;
	logic [tpt_pkg::QCNT_W-1:0]     count_q;

	assign full      = count_q == tpt_pkg::QCNT_W'(tpt_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = entries_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

/* sv/tpt_back.sv */
// Lookup engine: TLB and page table storage, hit/walk resolution, fills and result register.
`default_nettype none
`include "tlb_page_table_translate_defines.svh"

module tpt_back #(
	parameter int OFFSET_BITS   = 12,
	parameter int TLB_ENTRIES   = 16,
	parameter int VIRTUAL_PAGES = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pop_valid,
	input  tpt_pkg::entry_t                      pop_entry,
	output logic                                 pop,
	output logic                                 clear_busy,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [tpt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [tpt_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

	localparam int PAGE_W = $clog2(VIRTUAL_PAGES);
	localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int REM_W  = ((PAGE_W > SLOT_W) ? PAGE_W : SLOT_W) + 1;
	localparam logic [REM_W-1:0]  TLB_REM  = REM_W'(TLB_ENTRIES);
	localparam logic [PAGE_W-1:0] CLR_LAST = PAGE_W'(VIRTUAL_PAGES - 1);

	typedef enum logic [2:0] {
		BS_CLEAR   = 3'b001,
		BS_READ    = 3'b010,
		BS_RESOLVE = 3'b100
	} back_state_t;

	back_state_t                 state_q;
	logic [PAGE_W-1:0]           clr_q;
	logic [TLB_ENTRIES-1:0]      tlb_vld_q;
	logic                        out_valid_q;
	logic [tpt_pkg::PA_W-1:0]    pa_q;
	tpt_pkg::status_t            st_q;

	tpt_pkg::entry_t             e_q;
	logic [SLOT_W-1:0]           slot_q;

	logic [PAGE_W-1:0]           tlb_tag_mem  [TLB_ENTRIES];
	logic [tpt_pkg::FRAME_W-1:0] tlb_frm_mem  [TLB_ENTRIES];
	logic                        pv_mem       [VIRTUAL_PAGES];
	logic                        pro_mem      [VIRTUAL_PAGES];
	logic [tpt_pkg::FRAME_W-1:0] pfrm_mem     [VIRTUAL_PAGES];

	logic [PAGE_W-1:0]           tag_rd_q;
	logic [tpt_pkg::FRAME_W-1:0] tfrm_rd_q;
	logic                        pv_rd_q;
	logic                        pro_rd_q;
	logic [tpt_pkg::FRAME_W-1:0] pfrm_rd_q;

	logic [PAGE_W-1:0]           pop_page;
	logic [REM_W-1:0]            rem;
	logic [SLOT_W-1:0]           slot_d;
	logic [PAGE_W-1:0]           e_page;
	logic                        hit;
	logic                        clearing;
	logic                        commit;
	logic [tpt_pkg::FRAME_W-1:0] pa_frame;
	logic [31:0]                 pa_full;
	tpt_pkg::status_t            res_status;
	logic [tpt_pkg::PA_W-1:0]    res_pa;
	logic                        fill;
	logic                        map_wr;
	logic                        ro_wr;
	logic                        pv_we;
	logic                        pro_we;
	logic                        pro_wdata;
	logic [PAGE_W-1:0]           pt_wa;

	// slot = page - (page / TLB_ENTRIES) * TLB_ENTRIES, quotient from the front end
	assign pop_page = pop_entry.page[PAGE_W-1:0];
	assign rem      = REM_W'(pop_page) - REM_W'(REM_W'(pop_entry.quot[PAGE_W-1:0]) * TLB_REM);
	assign slot_d   = rem[SLOT_W-1:0];

	assign clearing   = state_q == BS_CLEAR;
	assign clear_busy = clearing;
	assign pop        = (state_q == BS_READ) && pop_valid;
	assign commit     = (state_q == BS_RESOLVE) && (!out_valid_q || m_axis_tready);

	assign e_page = e_q.page[PAGE_W-1:0];
	assign hit    = tlb_vld_q[slot_q] && e_q.in_range && (tag_rd_q == e_page);

	assign pa_frame = hit ? tfrm_rd_q : pfrm_rd_q;
	assign pa_full  = 32'({pa_frame, e_q.offset[OFFSET_BITS-1:0]});

	always_comb begin
		res_status = tpt_pkg::ST_BADPAGE;
		res_pa     = '0;
		fill       = 1'b0;
		map_wr     = 1'b0;
		ro_wr      = 1'b0;
		unique case (e_q.kind)
			tpt_pkg::K_TRANSLATE: begin
				priority if (hit) begin
					res_status = tpt_pkg::ST_HIT;
					res_pa     = pa_full[tpt_pkg::PA_W-1:0];
				end else if (!e_q.in_range) begin
					res_status = tpt_pkg::ST_RANGE;
				end else if (!pv_rd_q) begin
					res_status = tpt_pkg::ST_PFAULT;
				end else if (e_q.wr && pro_rd_q) begin
					res_status = tpt_pkg::ST_PROT;
				end else begin
					res_status = tpt_pkg::ST_FILLED;
					res_pa     = pa_full[tpt_pkg::PA_W-1:0];
					fill       = 1'b1;
				end
			end
			tpt_pkg::K_MAP: begin
				if (e_q.in_range) begin
					res_status = tpt_pkg::ST_DONE;
					map_wr     = 1'b1;
					ro_wr      = 1'b1;
				end
			end
			tpt_pkg::K_PROTECT: begin
				if (e_q.in_range) begin
					res_status = tpt_pkg::ST_DONE;
					ro_wr      = 1'b1;
				end
			end
			tpt_pkg::K_BAD: begin
				res_status = tpt_pkg::ST_BADPAGE;
			end
		endcase
	end

	// page table write port, shared with the post-reset sweep
	assign pt_wa     = clearing ? clr_q : e_page;
	assign pv_we     = clearing || (commit && map_wr);
	assign pro_we    = clearing || (commit && ro_wr);
	assign pro_wdata = clearing ? 1'b0 : e_q.ro;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_CLEAR;
			clr_q       <= '0;
			tlb_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BS_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) state_q <= BS_READ;
				end
				BS_READ: begin
					if (pop) state_q <= BS_RESOLVE;
				end
				BS_RESOLVE: begin
					if (commit) state_q <= BS_READ;
				end
				default: state_q <= BS_CLEAR;
			endcase
			if (commit && fill) tlb_vld_q[slot_q] <= 1'b1;
			if (commit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e_q    <= pop_entry;
			slot_q <= slot_d;
		end
		if (commit) begin
			pa_q <= res_pa;
			st_q <= res_status;
		end
	end

	// TLB storage
	always_ff @(posedge clk) begin
		if (pop) begin
			tag_rd_q  <= tlb_tag_mem[slot_d];
			tfrm_rd_q <= tlb_frm_mem[slot_d];
		end
		if (commit && fill) begin
			tlb_tag_mem[slot_q] <= e_page;
			tlb_frm_mem[slot_q] <= pfrm_rd_q;
		end
	end

	// page table storage
	always_ff @(posedge clk) begin
		if (pop) begin
			pv_rd_q   <= pv_mem[pop_page];
			pro_rd_q  <= pro_mem[pop_page];
			pfrm_rd_q <= pfrm_mem[pop_page];
		end
		if (pv_we) pv_mem[pt_wa] <= !clearing;
		if (pro_we) pro_mem[pt_wa] <= pro_wdata;
		if (commit && map_wr) pfrm_mem[pt_wa] <= e_q.frame;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(tpt_pkg::OUT_TDATA_W - tpt_pkg::PA_W){1'b0}}, pa_q};
	assign m_axis_tuser  = st_q;

	`TPT_ASSERT_NOW(a_no_pop_in_clear, clk, arst_n, clearing, !pop, "pop during clear sweep")
	`TPT_ASSERT_NEXT(a_pop_to_resolve, clk, arst_n, pop, state_q == BS_RESOLVE, "pop not followed by resolve")
	`TPT_ASSERT_NEXT(a_fill_sets_valid, clk, arst_n, commit && fill, tlb_vld_q[$past(slot_q)], "fill did not set TLB valid")
	`TPT_ASSERT_NOW(a_pa_zero_on_error, clk, arst_n, out_valid_q && st_q != tpt_pkg::ST_HIT && st_q != tpt_pkg::ST_FILLED, pa_q == '0, "nonzero address with error status")
	`TPT_ASSERT_NOW(a_hit_in_range, clk, arst_n, hit, e_q.in_range && e_q.kind == tpt_pkg::K_TRANSLATE || e_q.kind != tpt_pkg::K_TRANSLATE, "TLB hit on page outside table")

endmodule

`default_nettype wire

/* sv/tlb_page_table_translate.sv */
// Top level of the TLB / single-level page table address translation block.
`default_nettype none

// Translates virtual addresses through a direct-mapped TLB (slot = page mod TLB_ENTRIES)
// backed by a page table with per-page valid, frame and read-only marks; also maps pages
// and changes protection. One result beat per input beat, in order. The lookup engine
// takes one item at a time: a read state captures the TLB and page table memories at
// the item's slot and page, then a resolve state resolves hit/walk and writes the TLB
// fill or page table update, so a fill is seen by the very next item. An accepted beat
// passes the two-entry queue, the read registers and the output register; the queue and
// the output register let either side stall.
// After reset the page table runs a clearing sweep over all VIRTUAL_PAGES entries, during
// which s_axis_tready stays low.
module tlb_page_table_translate #(
	parameter int OFFSET_BITS   = 12,
	parameter int TLB_ENTRIES   = 16,
	parameter int VIRTUAL_PAGES = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// virtual_address[31:0], write_access[32], page_index[48:33], frame_value[64:49],
	// read_only_flag[65], zero pad[71:66]
	input  wire logic [tpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// operation[1:0]
	input  wire logic [tpt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// physical_address[27:0], zero pad[31:28]
	output logic [tpt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// status[2:0]
	output logic [tpt_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

	logic            clear_busy;
	logic            q_full;
	logic            push;
	tpt_pkg::entry_t push_entry;
	logic            pop;
	logic            pop_valid;
	tpt_pkg::entry_t pop_entry;

	tpt_front #(
		.OFFSET_BITS  (OFFSET_BITS),
		.TLB_ENTRIES  (TLB_ENTRIES),
		.VIRTUAL_PAGES(VIRTUAL_PAGES)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.clear_busy   (clear_busy),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	tpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry)
	);

	tpt_back #(
		.OFFSET_BITS  (OFFSET_BITS),
		.TLB_ENTRIES  (TLB_ENTRIES),
		.VIRTUAL_PAGES(VIRTUAL_PAGES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.clear_busy   (clear_busy),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

`default_nettype wire
